FILE: rtl/core/isg_pkg.sv
// Shared types and constants for the Ising spin-update block.
// Used by the channel interfaces and every module in rtl/core.
package isg_pkg;

  localparam int unsigned MAX_SIDE   = 64;
  localparam int unsigned IDX_W      = $clog2(MAX_SIDE);
  localparam int unsigned SIDE_W     = 7;
  localparam int unsigned COUP_W     = 5;
  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned THR_W      = 12;
  localparam int unsigned THR_N      = 5;
  localparam int unsigned TABLE_W    = THR_W * THR_N;
  localparam int unsigned DE_W       = 18;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = TABLE_W;
  localparam int unsigned FIFO_DEPTH = 2;

  // remainder unit: bits retired per cycle
  localparam int unsigned DIV_BITS   = 3;

  localparam logic [SIDE_W-1:0]         SIDE_RESET     = SIDE_W'(MAX_SIDE);
  localparam logic signed [COUP_W-1:0]  COUPLING_RESET = COUP_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIDE_LEN   = 3'd0,
    CFG_COUPLING   = 3'd1,
    CFG_FIELD      = 3'd2,
    CFG_UP_TABLE   = 3'd3,
    CFG_DOWN_TABLE = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RD_UP,
    B_RD_DN,
    B_EXEC
  } back_state_e;

  // one classified command, site and neighbor indexes already wrapped
  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row_up;
    logic [IDX_W-1:0] row_dn;
    logic [IDX_W-1:0] col_lf;
    logic [IDX_W-1:0] col_rt;
    logic             spin_value;
    logic [THR_W-1:0] uniform;
  } cmd_t;

  typedef struct packed {
    logic signed [COUP_W-1:0]  coupling;
    logic signed [FIELD_W-1:0] field_term;
    logic [TABLE_W-1:0]        up_table;
    logic [TABLE_W-1:0]        down_table;
  } cfg_t;

endpackage

FILE: rtl/core/isg_chan_if.sv
// Valid/ready channel interfaces for the Ising spin-update block.
// Depends on isg_pkg for field widths.
interface isg_in_if;
  import isg_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [IDX_W-1:0]        row;
  logic [IDX_W-1:0]        col;
  logic                    spin_value;
  logic [THR_W-1:0]        uniform;

  modport source (output valid, operation, row, col, spin_value, uniform, input ready);
  modport sink   (input valid, operation, row, col, spin_value, uniform, output ready);
endinterface

interface isg_out_if;
  import isg_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    spin_after;
  logic                    flipped;
  logic signed [DE_W-1:0]  energy_change;
  logic [CNT_W-1:0]        accepted_total;

  modport source (output valid, spin_after, flipped, energy_change, accepted_total,
                  input ready);
  modport sink   (input valid, spin_after, flipped, energy_change, accepted_total,
                  output ready);
endinterface

FILE: rtl/core/isg_front.sv
// Front end: accepts input items, wraps row/col modulo the side and derives
// the four neighbor indexes. Depends on isg_pkg and isg_in_if.
module isg_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  isg_in_if.sink                     in_i,
  input  logic [isg_pkg::SIDE_W-1:0] side_len_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output isg_pkg::cmd_t              push_data_o
);
  import isg_pkg::*;

  localparam int unsigned STEP_W = $clog2(IDX_W + DIV_BITS + 1);

  // one restoring remainder step: shift in a dividend bit, subtract if it fits
  function automatic logic [SIDE_W-1:0] rem_step(input logic [SIDE_W-1:0] rem,
                                                 input logic              b,
                                                 input logic [SIDE_W-1:0] side);
    logic [SIDE_W-1:0] t;
    t = {rem[SIDE_W-2:0], b};
    return (t >= side) ? (t - side) : t;
  endfunction

  front_state_e      state_q, state_d;
  logic [STEP_W-1:0] nsteps_q, nsteps_d;
  logic [SIDE_W-1:0] rrem_q, rrem_d, crem_q, crem_d;
  logic [IDX_W-1:0]  rdvd_q, rdvd_d, cdvd_q, cdvd_d;
  op_e               op_q, op_d;
  logic              spin_q, spin_d;
  logic [THR_W-1:0]  uniform_q, uniform_d;
  logic [SIDE_W-1:0] eff_side;
  logic [SIDE_W-1:0] rinc, cinc, rdec, cdec;

  always_comb begin
    if (side_len_i < SIDE_W'(2)) begin
      eff_side = SIDE_W'(2);
    end else if (side_len_i > SIDE_W'(MAX_SIDE)) begin
      eff_side = SIDE_W'(MAX_SIDE);
    end else begin
      eff_side = side_len_i;
    end
  end

  // wrapped neighbors of the reduced site
  always_comb begin
    rinc = rrem_q + SIDE_W'(1);
    cinc = crem_q + SIDE_W'(1);
    rdec = (rrem_q == '0) ? (eff_side - SIDE_W'(1)) : (rrem_q - SIDE_W'(1));
    cdec = (crem_q == '0) ? (eff_side - SIDE_W'(1)) : (crem_q - SIDE_W'(1));
    if (rinc == eff_side) rinc = '0;
    if (cinc == eff_side) cinc = '0;
  end

  assign push_data_o.op         = op_q;
  assign push_data_o.row        = rrem_q[IDX_W-1:0];
  assign push_data_o.col        = crem_q[IDX_W-1:0];
  assign push_data_o.row_up     = rdec[IDX_W-1:0];
  assign push_data_o.row_dn     = rinc[IDX_W-1:0];
  assign push_data_o.col_lf     = cdec[IDX_W-1:0];
  assign push_data_o.col_rt     = cinc[IDX_W-1:0];
  assign push_data_o.spin_value = spin_q;
  assign push_data_o.uniform    = uniform_q;

  always_comb begin
    state_d      = state_q;
    nsteps_d     = nsteps_q;
    rrem_d       = rrem_q;
    crem_d       = crem_q;
    rdvd_d       = rdvd_q;
    cdvd_d       = cdvd_q;
    op_d         = op_q;
    spin_d       = spin_q;
    uniform_d    = uniform_q;
    in_i.ready   = 1'b0;
    push_valid_o = 1'b0;

    case (state_q)
      F_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          op_d      = op_e'(in_i.operation);
          spin_d    = in_i.spin_value;
          uniform_d = in_i.uniform;
          rdvd_d    = in_i.row;
          cdvd_d    = in_i.col;
          rrem_d    = '0;
          crem_d    = '0;
          nsteps_d  = '0;
          state_d   = F_DIV;
        end
      end
      F_DIV: begin
        for (int j = 0; j < int'(DIV_BITS); j++) begin
          if ((int'(nsteps_q) + j) < int'(IDX_W)) begin
            rrem_d = rem_step(rrem_d, rdvd_d[IDX_W-1], eff_side);
            crem_d = rem_step(crem_d, cdvd_d[IDX_W-1], eff_side);
            rdvd_d = rdvd_d << 1;
            cdvd_d = cdvd_d << 1;
          end
        end
        nsteps_d = nsteps_q + STEP_W'(DIV_BITS);
        if ((int'(nsteps_q) + int'(DIV_BITS)) >= int'(IDX_W)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        push_valid_o = 1'b1;
        if (push_ready_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      nsteps_q <= '0;
    end else begin
      state_q  <= state_d;
      nsteps_q <= nsteps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rrem_q    <= rrem_d;
    crem_q    <= crem_d;
    rdvd_q    <= rdvd_d;
    cdvd_q    <= cdvd_d;
    op_q      <= op_d;
    spin_q    <= spin_d;
    uniform_q <= uniform_d;
  end

  a_site_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o |-> (rrem_q < eff_side) && (crem_q < eff_side))
    else $error("front: wrapped site not below the side");

endmodule

FILE: rtl/core/isg_fifo.sv
// Short command queue between the front end and the lattice engine.
// Depends on isg_pkg for cmd_t and FIFO_DEPTH.
module isg_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  isg_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output isg_pkg::cmd_t pop_data_o
);
  import isg_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             entry_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : (p + PTR_W'(1));
  endfunction

  assign push_ready_o = (count_q != CNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) count_d = count_q + CNT_W'(1);
    if (pop && !push) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_data_i;
  end

endmodule

FILE: rtl/core/isg_back.sv
// Lattice engine: holds the spin rows, runs write/read/Metropolis commands
// and owns the result register and flip counter. Depends on isg_pkg, isg_out_if.
module isg_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  isg_pkg::cmd_t pop_data_i,
  input  isg_pkg::cfg_t cfg_i,
  isg_out_if.source     out_o
);
  import isg_pkg::*;

  localparam int unsigned SUM_W = 5;
  localparam int unsigned JS_W  = COUP_W + SUM_W;

  function automatic logic [THR_W-1:0] thr_sel(input logic [TABLE_W-1:0] tab,
                                               input logic [2:0]         k);
    logic [THR_W-1:0] t;
    case (k)
      3'd0:    t = tab[0*THR_W +: THR_W];
      3'd1:    t = tab[1*THR_W +: THR_W];
      3'd2:    t = tab[2*THR_W +: THR_W];
      3'd3:    t = tab[3*THR_W +: THR_W];
      3'd4:    t = tab[4*THR_W +: THR_W];
      default: t = tab[0*THR_W +: THR_W];
    endcase
    return t;
  endfunction

  // one row of spins per word, bit = column
  logic [MAX_SIDE-1:0] lattice_mem [MAX_SIDE];
  logic [MAX_SIDE-1:0] rd_data_q;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [MAX_SIDE-1:0] wr_data;

  back_state_e          state_q, state_d;
  cmd_t                 cur_q, cur_d;
  logic [MAX_SIDE-1:0]  row_c_q, row_c_d, row_p_q, row_p_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_spin_q, out_spin_d;
  logic                 out_flip_q, out_flip_d;
  logic signed [DE_W-1:0] out_de_q, out_de_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  logic [MAX_SIDE-1:0]  row_cur;
  logic                 self_s, nb_up, nb_dn, nb_lf, nb_rt;
  logic [2:0]           ones;
  logic signed [SUM_W-1:0] nsum;
  logic signed [JS_W-1:0]  jsum;
  logic signed [DE_W-1:0]  e_loc, de;
  logic [2:0]           k;
  logic [THR_W-1:0]     thr;
  logic                 flip, new_bit, fire, is_step;

  // write back to the command's own row; the read port may be parked elsewhere
  always_ff @(posedge clk_i) begin
    if (wr_en) lattice_mem[cur_q.row] <= wr_data;
    rd_data_q <= lattice_mem[rd_addr];
  end

  // energy and acceptance for the current command
  always_comb begin
    is_step = (cur_q.op == OP_STEP);
    row_cur = is_step ? row_c_q : rd_data_q;
    self_s  = row_cur[cur_q.col];
    nb_lf   = row_cur[cur_q.col_lf];
    nb_rt   = row_cur[cur_q.col_rt];
    nb_up   = row_p_q[cur_q.col];
    nb_dn   = rd_data_q[cur_q.col];
    ones    = 3'({2'b0, nb_up} + {2'b0, nb_dn} + {2'b0, nb_lf} + {2'b0, nb_rt});
    nsum    = $signed({1'b0, ones, 1'b0}) - SUM_W'(4);
    jsum    = cfg_i.coupling * nsum;
    e_loc   = (DE_W'(jsum) <<< 8) + DE_W'(cfg_i.field_term);
    de      = self_s ? (e_loc <<< 1) : -(e_loc <<< 1);
    k       = self_s ? ones : (3'd4 - ones);
    thr     = thr_sel(self_s ? cfg_i.up_table : cfg_i.down_table, k);
    flip    = de[DE_W-1] || (de == '0) || (cur_q.uniform < thr);
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    row_c_d     = row_c_q;
    row_p_d     = row_p_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_spin_d  = out_spin_q;
    out_flip_d  = out_flip_q;
    out_de_d    = out_de_q;
    cnt_d       = cnt_q;
    pop_ready_o = 1'b0;
    rd_addr     = cur_q.row;
    wr_en       = 1'b0;
    wr_data     = row_cur;
    new_bit     = self_s;
    fire        = 1'b0;

    case (state_q)
      B_IDLE: begin
        pop_ready_o = 1'b1;
        rd_addr     = pop_data_i.row;
        if (pop_valid_i) begin
          cur_d   = pop_data_i;
          state_d = (pop_data_i.op == OP_STEP) ? B_RD_UP : B_EXEC;
        end
      end
      B_RD_UP: begin
        rd_addr = cur_q.row_up;
        row_c_d = rd_data_q;
        state_d = B_RD_DN;
      end
      B_RD_DN: begin
        rd_addr = cur_q.row_dn;
        row_p_d = rd_data_q;
        state_d = B_EXEC;
      end
      B_EXEC: begin
        // keep re-reading the last row so its data holds while stalled
        rd_addr = is_step ? cur_q.row_dn : cur_q.row;
        fire    = !out_valid_q || out_o.ready;
        case (cur_q.op)
          OP_WRITE: new_bit = cur_q.spin_value;
          OP_STEP:  new_bit = self_s ^ flip;
          default:  new_bit = self_s;
        endcase
        wr_data[cur_q.col] = new_bit;
        if (fire) begin
          wr_en       = (cur_q.op == OP_WRITE) || (is_step && flip);
          out_valid_d = 1'b1;
          out_spin_d  = new_bit;
          out_flip_d  = is_step && flip;
          out_de_d    = is_step ? de : '0;
          if (is_step && flip && (cnt_q != '1)) cnt_d = cnt_q + CNT_W'(1);
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    row_c_q    <= row_c_d;
    row_p_q    <= row_p_d;
    out_spin_q <= out_spin_d;
    out_flip_q <= out_flip_d;
    out_de_q   <= out_de_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.spin_after     = out_spin_q;
  assign out_o.flipped        = out_flip_q;
  assign out_o.energy_change  = out_de_q;
  assign out_o.accepted_total = cnt_q;

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("back: flip counter moved by other than one");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == B_EXEC))
    else $error("back: result appeared outside execute");

  a_non_step_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !is_step) |=> (!out_flip_q && (out_de_q == '0)))
    else $error("back: write or read reported a flip or energy");

endmodule

FILE: rtl/core/ising_metropolis_spin_update.sv
// Top level of the Ising single-spin-flip Metropolis block.
// Depends on isg_pkg, isg_chan_if, isg_front, isg_fifo and isg_back.
//
// Usage: items enter on in_i (operation, row, col, spin_value, uniform) and
// each gives exactly one result on out_o (spin_after, flipped, energy_change,
// accepted_total). Both are valid/ready channels; a transfer happens on a
// rising edge with valid and ready high. Registers are to be written through
// cfg_we_i/cfg_idx_i/cfg_wdata_i only while the block is idle; the user must
// keep to this, as the block itself does not enforce it. Items are paced by
// the front end's remainder unit (row/col mod side, 3 bits a cycle), which
// takes a new item only once it has pushed the last one to the queue, and by
// the engine's single lattice read port, which fetches three rows per step.
// Reset clears the flip counter, the queue and all handshakes, and loads
// the register defaults; lattice contents are not cleared and a site must
// be written before it is read or used as a neighbor.
// When out_o stalls the result holds in the output register, the engine
// waits in its execute stage, the two-entry queue fills, then in_i drops
// ready.
module ising_metropolis_spin_update (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  isg_in_if.sink                         in_i,
  isg_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [isg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [isg_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import isg_pkg::*;

  logic [SIDE_W-1:0]         side_q;
  logic signed [COUP_W-1:0]  coupling_q;
  logic signed [FIELD_W-1:0] field_q;
  logic [TABLE_W-1:0]        up_table_q, down_table_q;
  cfg_t                      cfg;

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q       <= SIDE_RESET;
      coupling_q   <= COUPLING_RESET;
      field_q      <= '0;
      up_table_q   <= '0;
      down_table_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SIDE_LEN:   side_q       <= cfg_wdata_i[SIDE_W-1:0];
        CFG_COUPLING:   coupling_q   <= cfg_wdata_i[COUP_W-1:0];
        CFG_FIELD:      field_q      <= cfg_wdata_i[FIELD_W-1:0];
        CFG_UP_TABLE:   up_table_q   <= cfg_wdata_i[TABLE_W-1:0];
        CFG_DOWN_TABLE: down_table_q <= cfg_wdata_i[TABLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.coupling   = coupling_q;
  assign cfg.field_term = field_q;
  assign cfg.up_table   = up_table_q;
  assign cfg.down_table = down_table_q;

  isg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .side_len_i   (side_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  isg_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  isg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .cfg_i       (cfg),
    .out_o       (out_o)
  );

endmodule

FILE: sim/ising_metropolis_spin_update_test.sv
// Self-checking testbench for ising_metropolis_spin_update: a directed table, then
// random phases under several register settings and handshake idling patterns.
// Depends on isg_pkg, isg_chan_if and the RTL under rtl/core.
module ising_metropolis_spin_update_test;
  import isg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // operation 3 has no enum member; the block treats it as a read
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 10;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             spin_value;
    logic [THR_W-1:0] uniform;
  } site_cmd_t;

  typedef struct packed {
    logic                   spin_after;
    logic                   flipped;
    logic signed [DE_W-1:0] energy_change;
    logic [CNT_W-1:0]       accepted_total;
  } site_report_t;

  typedef struct packed {
    site_cmd_t    cmd;
    logic         typed;
    site_report_t want;
  } plan_row_t;

  // default registers: side 64, J = 1, no field, zero thresholds
  localparam plan_row_t DIRECTED [20] = '{
    '{'{OP_WRITE, 6'd0,  6'd0,  1'b1, 12'd0},    1'b1, '{1'b1, 1'b0, 18'sd0, 32'd0}},
    '{'{OP_WRITE, 6'd63, 6'd0,  1'b1, 12'd0},    1'b1, '{1'b1, 1'b0, 18'sd0, 32'd0}},
    '{'{OP_WRITE, 6'd1,  6'd0,  1'b1, 12'd0},    1'b1, '{1'b1, 1'b0, 18'sd0, 32'd0}},
    '{'{OP_WRITE, 6'd0,  6'd63, 1'b1, 12'd0},    1'b1, '{1'b1, 1'b0, 18'sd0, 32'd0}},
    '{'{OP_WRITE, 6'd0,  6'd1,  1'b1, 12'd0},    1'b1, '{1'b1, 1'b0, 18'sd0, 32'd0}},
    '{'{OP_READ,  6'd0,  6'd0,  1'b0, 12'd0},    1'b1, '{1'b1, 1'b0, 18'sd0, 32'd0}},
    '{'{OP_SPARE, 6'd0,  6'd0,  1'b0, 12'd0},    1'b1, '{1'b1, 1'b0, 18'sd0, 32'd0}},
    // uphill with a zero threshold never flips, even at the top uniform
    '{'{OP_STEP,  6'd0,  6'd0,  1'b0, 12'd4095}, 1'b1, '{1'b1, 1'b0, 18'sd2048, 32'd0}},
    '{'{OP_WRITE, 6'd0,  6'd0,  1'b0, 12'd4095}, 1'b1, '{1'b0, 1'b0, 18'sd0, 32'd0}},
    '{'{OP_STEP,  6'd0,  6'd0,  1'b1, 12'd0},    1'b1, '{1'b1, 1'b1, -18'sd2048, 32'd1}},
    '{'{OP_WRITE, 6'd0,  6'd1,  1'b0, 12'd0},    1'b1, '{1'b0, 1'b0, 18'sd0, 32'd1}},
    '{'{OP_WRITE, 6'd0,  6'd63, 1'b0, 12'd0},    1'b1, '{1'b0, 1'b0, 18'sd0, 32'd1}},
    // zero energy change is accepted
    '{'{OP_STEP,  6'd0,  6'd0,  1'b0, 12'd4095}, 1'b1, '{1'b0, 1'b1, 18'sd0, 32'd2}},
    '{'{OP_WRITE, 6'd63, 6'd63, 1'b0, 12'd0},    1'b1, '{1'b0, 1'b0, 18'sd0, 32'd2}},
    '{'{OP_WRITE, 6'd62, 6'd63, 1'b1, 12'd0},    1'b1, '{1'b1, 1'b0, 18'sd0, 32'd2}},
    '{'{OP_WRITE, 6'd63, 6'd62, 1'b0, 12'd0},    1'b1, '{1'b0, 1'b0, 18'sd0, 32'd2}},
    '{'{OP_STEP,  6'd63, 6'd63, 1'b1, 12'd2048}, 1'b0, '0},
    '{'{OP_READ,  6'd63, 6'd63, 1'b1, 12'd0},    1'b0, '0},
    '{'{OP_WRITE, 6'd42, 6'd21, 1'b1, 12'd2730}, 1'b0, '0},
    '{'{OP_SPARE, 6'd42, 6'd21, 1'b0, 12'd1365}, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  isg_in_if  in_if ();
  isg_out_if out_if ();

  ising_metropolis_spin_update u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // shadow of the block: lattice, flip tally and registers
  bit                        shadow_spins [MAX_SIDE*MAX_SIDE];
  bit                        site_written [MAX_SIDE*MAX_SIDE];
  logic [CNT_W-1:0]          flip_tally = '0;
  logic [SIDE_W-1:0]         cur_side = SIDE_RESET;
  logic signed [COUP_W-1:0]  cur_coupling = COUPLING_RESET;
  logic signed [FIELD_W-1:0] cur_field = '0;
  logic [TABLE_W-1:0]        up_thresholds = '0;
  logic [TABLE_W-1:0]        down_thresholds = '0;

  site_report_t spin_reports_due [$];
  int unsigned  fail_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned side_in_use();
    if (cur_side < 2) return 2;
    if (cur_side > MAX_SIDE) return MAX_SIDE;
    return cur_side;
  endfunction

  function automatic int spin_sign(int unsigned r, int unsigned c);
    return shadow_spins[r*MAX_SIDE + c] ? 1 : -1;
  endfunction

  task automatic metropolis_apply(input site_cmd_t cmd, output site_report_t res);
    int unsigned side, r, c, site, k;
    int nsum, s, de;
    logic [TABLE_W-1:0] tab;
    logic [THR_W-1:0] thr;
    side = side_in_use();
    r = cmd.row % side;
    c = cmd.col % side;
    site = r*MAX_SIDE + c;
    res = '0;
    case (cmd.op)
      OP_WRITE: begin
        shadow_spins[site] = cmd.spin_value;
        site_written[site] = 1'b1;
      end
      OP_STEP: begin
        nsum = spin_sign((r + 1) % side, c) + spin_sign((r + side - 1) % side, c)
             + spin_sign(r, (c + 1) % side) + spin_sign(r, (c + side - 1) % side);
        s = shadow_spins[site] ? 1 : -1;
        k = (s*nsum + 4) / 2;
        tab = shadow_spins[site] ? up_thresholds : down_thresholds;
        thr = tab[k*THR_W +: THR_W];
        de = 2 * s * (int'(cur_coupling) * nsum * 256 + int'(cur_field));
        if (de <= 0 || cmd.uniform < thr) begin
          shadow_spins[site] = !shadow_spins[site];
          res.flipped = 1'b1;
          if (flip_tally != '1) flip_tally++;
        end
        res.energy_change = DE_W'(de);
      end
      default: ;
    endcase
    res.spin_after = shadow_spins[site];
    res.accepted_total = flip_tally;
  endtask

  // turn a read or step that would touch an unwritten site into a write of that site
  function automatic site_cmd_t legalize(site_cmd_t cmd);
    int unsigned side, r, c, n;
    int unsigned rows [5];
    int unsigned cols [5];
    side = side_in_use();
    r = cmd.row % side;
    c = cmd.col % side;
    rows = '{r, (r + 1) % side, (r + side - 1) % side, r, r};
    cols = '{c, c, c, (c + 1) % side, (c + side - 1) % side};
    n = (cmd.op == OP_WRITE) ? 0 : (cmd.op == OP_STEP) ? 5 : 1;
    for (int i = 0; i < n; i++) begin
      if (!site_written[rows[i]*MAX_SIDE + cols[i]]) begin
        cmd.op = OP_WRITE;
        cmd.row = IDX_W'(rows[i]);
        cmd.col = IDX_W'(cols[i]);
        return cmd;
      end
    end
    return cmd;
  endfunction

  // mostly a small corner of the lattice so reads and steps find written sites
  function automatic logic [IDX_W-1:0] pick_coord();
    if ($urandom_range(99) < 70) return IDX_W'($urandom_range(7));
    return IDX_W'($urandom);
  endfunction

  function automatic site_cmd_t random_cmd();
    site_cmd_t cmd;
    int unsigned pick;
    pick = $urandom_range(99);
    cmd.op = pick < 15 ? OP_WRITE : pick < 75 ? OP_STEP : pick < 92 ? OP_READ : OP_SPARE;
    cmd.row = pick_coord();
    cmd.col = pick_coord();
    cmd.spin_value = 1'($urandom_range(1));
    if ($urandom_range(3) == 0) cmd.uniform = $urandom_range(1) ? '1 : '0;
    else cmd.uniform = THR_W'($urandom);
    return legalize(cmd);
  endfunction

  function automatic logic [TABLE_W-1:0] random_table();
    return TABLE_W'({$urandom, $urandom});
  endfunction

  task automatic send_cmd(input site_cmd_t cmd, input logic typed, input site_report_t want);
    site_report_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.operation  <= cmd.op;
    in_if.row        <= cmd.row;
    in_if.col        <= cmd.col;
    in_if.spin_value <= cmd.spin_value;
    in_if.uniform    <= cmd.uniform;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    metropolis_apply(cmd, got);
    spin_reports_due.push_back(typed ? want : got);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (spin_reports_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input int side, input int coup, input int field,
                           input logic [TABLE_W-1:0] up_tab, input logic [TABLE_W-1:0] dn_tab,
                           input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned n_cmds);
    drain();
    cfg_write(CFG_SIDE_LEN, CFG_DATA_W'(SIDE_W'(side)));
    cfg_write(CFG_COUPLING, CFG_DATA_W'(COUP_W'(coup)));
    cfg_write(CFG_FIELD, CFG_DATA_W'(FIELD_W'(field)));
    cfg_write(CFG_UP_TABLE, up_tab);
    cfg_write(CFG_DOWN_TABLE, dn_tab);
    cfg_we_i <= 1'b0;
    cur_side        = SIDE_W'(side);
    cur_coupling    = COUP_W'(coup);
    cur_field       = FIELD_W'(field);
    up_thresholds   = up_tab;
    down_thresholds = dn_tab;
    send_idle_pct   = send_pct;
    recv_stall_pct  = recv_pct;
    repeat (n_cmds) send_cmd(random_cmd(), 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    site_report_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (spin_reports_due.size() == 0) begin
        $error("result transfer with nothing outstanding");
        fail_count++;
      end else begin
        want = spin_reports_due.pop_front();
        if (out_if.spin_after !== want.spin_after) begin
          $error("spin_after: expected %0d, got %0d", want.spin_after, out_if.spin_after);
          fail_count++;
        end
        if (out_if.flipped !== want.flipped) begin
          $error("flipped: expected %0d, got %0d", want.flipped, out_if.flipped);
          fail_count++;
        end
        if (out_if.energy_change !== want.energy_change) begin
          $error("energy_change: expected %0d, got %0d", want.energy_change,
                 out_if.energy_change);
          fail_count++;
        end
        if (out_if.accepted_total !== want.accepted_total) begin
          $error("accepted_total: expected %0d, got %0d", want.accepted_total,
                 out_if.accepted_total);
          fail_count++;
        end
      end
    end
  end

  // end the run if no transfer happens on either channel for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.operation  = OP_WRITE;
    in_if.row        = '0;
    in_if.col        = '0;
    in_if.spin_value = 1'b0;
    in_if.uniform    = '0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_SIDE_LEN;
    cfg_wdata_i      = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i]) send_cmd(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].want);

    run_phase(64, 1, 0, random_table(), random_table(), 0, 0, 80);
    run_phase(2, 15, 32767, '1, random_table(), 84, 0, 80);
    // side 0 and side 127 fold to the nearest legal side
    run_phase(0, -16, -32768, random_table(), '1, 0, 84, 80);
    run_phase(127, -8, $urandom_range(65535), random_table(), random_table(), 33, 33, 80);
    run_phase(5, 8, 0, random_table(), random_table(), 0, 0, 80);
    run_phase(1, 0, $urandom_range(65535), '0, '0, 84, 0, 60);
    run_phase(3, $urandom_range(31), $urandom_range(65535), random_table(), random_table(),
              0, 84, 80);
    run_phase(64, $urandom_range(31), $urandom_range(65535), '1, '1, 33, 33, 80);
    run_phase($urandom_range(2, 8), $urandom_range(31), $urandom_range(2047) - 1024,
              random_table(), random_table(), 0, 0, 80);

    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/isg_pkg.sv
rtl/core/isg_chan_if.sv
rtl/core/isg_front.sv
rtl/core/isg_fifo.sv
rtl/core/isg_back.sv
rtl/core/ising_metropolis_spin_update.sv
sim/ising_metropolis_spin_update_test.sv
